/* hdl/indexed_deque_store_defines.svh */
// Assertion macros for the indexed deque store.
// Used by the top level; expects clock and reset in scope.
`ifndef INDEXED_DEQUE_STORE_DEFINES_SVH
`define INDEXED_DEQUE_STORE_DEFINES_SVH

// check a consequence in the same cycle
`define IDS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// check a consequence in the next cycle
`define IDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ids_pkg.sv */
// Shared types and constants for the indexed deque store.
// No dependencies; imported by the top level, the datapath, the controller and the testbench.
`default_nettype none

package ids_pkg;

   localparam int DEPTH_DEF   = 64;
   localparam int DATA_W_DEF  = 32;

   localparam int OPCODE_W    = 3;
   localparam int VALUE_W     = 32;
   localparam int POSITION_W  = 6;
   localparam int READ_DATA_W = 32;
   localparam int STATUS_W    = 2;
   localparam int COUNT_W     = 7;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_READ_FRONT = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_READ_BACK  = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_READ_AT    = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_REMOVE_AT  = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_OOB   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

   localparam logic [2:0] ADDR_COUNT     = 3'd0;
   localparam logic [2:0] ADDR_ONE       = 3'd1;
   localparam logic [2:0] ADDR_FRONT     = 3'd2;
   localparam logic [2:0] ADDR_LAST      = 3'd3;
   localparam logic [2:0] ADDR_POS       = 3'd4;
   localparam logic [2:0] ADDR_IDX1      = 3'd5;
   localparam logic [2:0] ADDR_IDX       = 3'd6;
   localparam logic [2:0] ADDR_FRONT_DEC = 3'd7;

   localparam logic [1:0] FRONT_HOLD = 2'd0;
   localparam logic [1:0] FRONT_SLOT = 2'd1;
   localparam logic [1:0] FRONT_DEC  = 2'd2;

   typedef struct packed {
      logic       capture;
      logic       mem_we;
      logic       wdata_mem;
      logic [2:0] addr_sel;
      logic [1:0] front_step;
      logic       count_inc;
      logic       count_dec;
      logic       idx_load;
      logic       idx_inc;
      logic       stat_load;
      logic       rdata_clear;
      logic       rdata_load;
      logic       rsp_load;
   } ids_cmd_type;

   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                full;
      logic                empty;
      logic                oob;
      logic                more;
      logic                move_more;
   } ids_stat_type;

endpackage

`default_nettype wire

/* hdl/indexed_deque_store.sv */
// Indexed deque store: ring-buffer deque with push/pop/read at both ends,
// read at index and remove at index; one result per transaction.
// Each transaction runs an execute and a respond state; reads add a RAM wait
// state; remove at index alternates move-read and move-write states, bound by
// the single RAM port. Requests are taken only when idle or in the respond state.
// Reset: store empty, front at slot 0, ready on the cycle after reset.
`include "indexed_deque_store_defines.svh"
`default_nettype none

module indexed_deque_store import ids_pkg::*; #(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int DATA_W = DATA_W_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,  // value[31:0], position[37:32], zero pad
   input  wire logic [OPCODE_W-1:0]    req_tuser,  // opcode[2:0]
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,  // read_data[31:0], count[38:32], zero pad
   output logic      [STATUS_W-1:0]    rsp_tuser   // status[1:0]
);

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

   ids_cmd_type              cmd;
   ids_stat_type             stat;
   logic [READ_DATA_W-1:0]   rsp_read_data;
   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_W-1:0]       rsp_count;

   ids_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ids_datapath #(
      .DEPTH  (DEPTH),
      .DATA_W (DATA_W)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_opcode    (req_tuser),
      .req_value     (req_tdata[VALUE_W-1:0]),
      .req_position  (req_tdata[VALUE_W+POSITION_W-1:VALUE_W]),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - READ_DATA_W - COUNT_W){1'b0}}, rsp_count, rsp_read_data};
   assign rsp_tuser = rsp_status;

   `IDS_ASSERT_NOW(a_full_count, rsp_tvalid && rsp_status == ST_FULL, rsp_count == FULL_COUNT, "full status with count below depth")
   `IDS_ASSERT_NOW(a_empty_count, rsp_tvalid && rsp_status == ST_EMPTY, rsp_count == '0, "empty status with nonzero count")
   `IDS_ASSERT_NOW(a_data_ok, rsp_tvalid && rsp_read_data != '0, rsp_status == ST_OK, "read data on a failed transaction")
   `IDS_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "accepted a transaction while executing")

endmodule

`default_nettype wire

/* hdl/ids_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ids_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

/* hdl/ids_datapath.sv */
// Datapath of the indexed deque store: ring front pointer, entry count, item and
// result registers and the entry RAM. Depends on ids_pkg and ids_ram.
`default_nettype none

module ids_datapath import ids_pkg::*; #(
   parameter int DEPTH  = DEPTH_DEF,
   parameter int DATA_W = DATA_W_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ids_cmd_type            cmd,
   output ids_stat_type                stat,
   input  wire logic [OPCODE_W-1:0]    req_opcode,
   input  wire logic [VALUE_W-1:0]     req_value,
   input  wire logic [POSITION_W-1:0]  req_position,
   output logic      [READ_DATA_W-1:0] rsp_read_data,
   output logic      [STATUS_W-1:0]    rsp_status,
   output logic      [COUNT_W-1:0]     rsp_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int SW   = CW + 1;
   localparam int CMPW = CW + POSITION_W;

   logic [OPCODE_W-1:0]    op_ff, op_in;
   logic [DATA_W-1:0]      val_ff, val_in;
   logic [POSITION_W-1:0]  pos_ff, pos_in;
   logic [AW-1:0]          front_ff, front_in;
   logic [CW-1:0]          count_ff, count_in;
   logic [CW-1:0]          idx_ff, idx_in;
   logic [STATUS_W-1:0]    stat_ff, stat_in;
   logic [DATA_W-1:0]      rdata_ff, rdata_in;
   logic [READ_DATA_W-1:0] out_data_ff, out_data_in;
   logic [STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [COUNT_W-1:0]     out_count_ff, out_count_in;

   logic [VALUE_W+DATA_W-1:0]     value_ext;
   logic [DATA_W+READ_DATA_W-1:0] rd_ext;
   logic [CW+COUNT_W-1:0]         count_ext;
   logic [CMPW-1:0]               pos_cmp;
   logic [CMPW-1:0]               count_cmp;
   logic [CW-1:0]                 ofs;
   logic [SW-1:0]                 sum;
   logic [SW-1:0]                 wrap;
   logic [AW-1:0]                 slot;
   logic [AW-1:0]                 front_dec;
   logic [AW-1:0]                 mem_addr;
   logic [DATA_W-1:0]             mem_wdata;
   logic [DATA_W-1:0]             mem_rdata;
   logic                          full;
   logic                          empty;
   logic                          oob;
   logic [STATUS_W-1:0]           code;

   assign value_ext = {{DATA_W{1'b0}}, req_value};
   assign rd_ext    = {{READ_DATA_W{1'b0}}, rdata_ff};
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};
   assign pos_cmp   = {{CW{1'b0}}, pos_ff};
   assign count_cmp = {{POSITION_W{1'b0}}, count_ff};

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign oob   = (pos_cmp >= count_cmp);

   assign stat.op        = op_ff;
   assign stat.full      = full;
   assign stat.empty     = empty;
   assign stat.oob       = oob;
   assign stat.more      = ((pos_cmp + CMPW'(1)) < count_cmp);
   assign stat.move_more = (({1'b0, idx_ff} + SW'(2)) < {1'b0, count_ff});

   always_comb begin
      if (op_ff inside {OP_PUSH_BACK, OP_PUSH_FRONT}) begin
         code = full ? ST_FULL : ST_OK;
      end else if (empty) begin
         code = ST_EMPTY;
      end else if ((op_ff inside {OP_READ_AT, OP_REMOVE_AT}) && oob) begin
         code = ST_OOB;
      end else begin
         code = ST_OK;
      end
   end

   always_comb begin
      case (cmd.addr_sel)
         ADDR_COUNT: ofs = count_ff;
         ADDR_ONE:   ofs = CW'(1);
         ADDR_FRONT: ofs = '0;
         ADDR_LAST:  ofs = count_ff - CW'(1);
         ADDR_POS:   ofs = pos_cmp[CW-1:0];
         ADDR_IDX1:  ofs = idx_ff + CW'(1);
         ADDR_IDX:   ofs = idx_ff;
         default:    ofs = '0;
      endcase
   end

   assign sum       = SW'(front_ff) + SW'(ofs);
   assign wrap      = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
   assign slot      = wrap[AW-1:0];
   assign front_dec = (front_ff == '0) ? AW'(DEPTH - 1) : (front_ff - AW'(1));
   assign mem_addr  = (cmd.addr_sel == ADDR_FRONT_DEC) ? front_dec : slot;
   assign mem_wdata = cmd.wdata_mem ? mem_rdata : val_ff;

   ids_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (cmd.mem_we),
      .waddr (mem_addr),
      .wdata (mem_wdata),
      .raddr (mem_addr),
      .rdata (mem_rdata)
   );

   always_comb begin
      op_in         = op_ff;
      val_in        = val_ff;
      pos_in        = pos_ff;
      front_in      = front_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      stat_in       = stat_ff;
      rdata_in      = rdata_ff;
      out_data_in   = out_data_ff;
      out_status_in = out_status_ff;
      out_count_in  = out_count_ff;
      if (cmd.capture) begin
         op_in  = req_opcode;
         val_in = value_ext[DATA_W-1:0];
         pos_in = req_position;
      end
      case (cmd.front_step)
         FRONT_HOLD: front_in = front_ff;
         FRONT_SLOT: front_in = slot;
         FRONT_DEC:  front_in = front_dec;
         default:    front_in = front_ff;
      endcase
      if (cmd.count_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.idx_load) begin
         idx_in = pos_cmp[CW-1:0];
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + CW'(1);
      end
      if (cmd.stat_load) begin
         stat_in = code;
      end
      if (cmd.rdata_clear) begin
         rdata_in = '0;
      end else if (cmd.rdata_load) begin
         rdata_in = mem_rdata;
      end
      if (cmd.rsp_load) begin
         out_data_in   = rd_ext[READ_DATA_W-1:0];
         out_status_in = stat_ff;
         out_count_in  = count_ext[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      val_ff        <= val_in;
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      stat_ff       <= stat_in;
      rdata_ff      <= rdata_in;
      out_data_ff   <= out_data_in;
      out_status_ff <= out_status_in;
      out_count_ff  <= out_count_in;
   end

   assign rsp_read_data = out_data_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_count     = out_count_ff;

endmodule

`default_nettype wire

/* hdl/ids_ctrl.sv */
// Controller of the indexed deque store: sequences each transaction and
// owns the handshakes. Depends on ids_pkg.
`default_nettype none

module ids_ctrl import ids_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire ids_stat_type stat,
   output ids_cmd_type       cmd
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_RDWAIT  = 3'd2;
   localparam logic [2:0] S_MOVE_RD = 3'd3;
   localparam logic [2:0] S_MOVE_WR = 3'd4;
   localparam logic [2:0] S_RESP    = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       out_free;

   assign out_free   = !valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) || ((state_ff == S_RESP) && out_free);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.stat_load   = 1'b1;
            cmd.rdata_clear = 1'b1;
            state_in        = S_RESP;
            case (stat.op)
               OP_PUSH_BACK: begin
                  if (!stat.full) begin
                     cmd.mem_we    = 1'b1;
                     cmd.addr_sel  = ADDR_COUNT;
                     cmd.count_inc = 1'b1;
                  end
               end
               OP_PUSH_FRONT: begin
                  if (!stat.full) begin
                     cmd.mem_we     = 1'b1;
                     cmd.addr_sel   = ADDR_FRONT_DEC;
                     cmd.front_step = FRONT_DEC;
                     cmd.count_inc  = 1'b1;
                  end
               end
               OP_POP_FRONT: begin
                  if (!stat.empty) begin
                     cmd.addr_sel   = ADDR_ONE;
                     cmd.front_step = FRONT_SLOT;
                     cmd.count_dec  = 1'b1;
                  end
               end
               OP_POP_BACK: begin
                  if (!stat.empty) begin
                     cmd.count_dec = 1'b1;
                  end
               end
               OP_READ_FRONT: begin
                  cmd.addr_sel = ADDR_FRONT;
                  if (!stat.empty) begin
                     state_in = S_RDWAIT;
                  end
               end
               OP_READ_BACK: begin
                  cmd.addr_sel = ADDR_LAST;
                  if (!stat.empty) begin
                     state_in = S_RDWAIT;
                  end
               end
               OP_READ_AT: begin
                  cmd.addr_sel = ADDR_POS;
                  if (!stat.empty && !stat.oob) begin
                     state_in = S_RDWAIT;
                  end
               end
               OP_REMOVE_AT: begin
                  if (!stat.empty && !stat.oob) begin
                     cmd.idx_load = 1'b1;
                     if (stat.more) begin
                        state_in = S_MOVE_RD;
                     end else begin
                        cmd.count_dec = 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_RDWAIT: begin
            cmd.rdata_load = 1'b1;
            state_in       = S_RESP;
         end
         S_MOVE_RD: begin
            cmd.addr_sel = ADDR_IDX1;
            state_in     = S_MOVE_WR;
         end
         S_MOVE_WR: begin
            cmd.mem_we    = 1'b1;
            cmd.wdata_mem = 1'b1;
            cmd.addr_sel  = ADDR_IDX;
            cmd.idx_inc   = 1'b1;
            if (stat.move_more) begin
               state_in = S_MOVE_RD;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = S_RESP;
            end
         end
         S_RESP: begin
            if (out_free) begin
               cmd.rsp_load = 1'b1;
               if (req_tvalid) begin
                  cmd.capture = 1'b1;
                  state_in    = S_EXEC;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.rsp_load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

/* dv/indexed_deque_store_tb.sv */
// Self-checking testbench for the indexed deque store: drives push, pop, read and
// remove transactions and checks every response against a queue-based deque predictor.
// Depends on ids_pkg and the indexed_deque_store RTL.
`timescale 1ns / 1ps

module indexed_deque_store_tb;
   import ids_pkg::*;

   localparam int          STORE_DEPTH  = DEPTH_DEF;
   localparam int unsigned RANDOM_ITEMS = 1750;
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int          MIX_GROW     = 0;
   localparam int          MIX_EVEN     = 1;
   localparam int          MIX_SHRINK   = 2;

   typedef struct packed {
      logic [READ_DATA_W-1:0] read_data;
      logic [STATUS_W-1:0]    status;
      logic [COUNT_W-1:0]     count;
   } deque_result_type;

   class deque_scoreboard;
      logic [VALUE_W-1:0] contents[$];
      deque_result_type   expected[$];
      int unsigned        errors;
      int unsigned        checked;

      function new();
         errors  = 0;
         checked = 0;
      endfunction

      function void note_request(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value,
                                 logic [POSITION_W-1:0] pos);
         deque_result_type res;
         res = '0;
         res.status = ST_OK;
         if (op == OP_PUSH_BACK || op == OP_PUSH_FRONT) begin
            if (contents.size() >= STORE_DEPTH)
               res.status = ST_FULL;
            else if (op == OP_PUSH_BACK)
               contents.push_back(value);
            else
               contents.push_front(value);
         end else if (contents.size() == 0) begin
            res.status = ST_EMPTY;
         end else begin
            case (op)
               OP_POP_FRONT:  void'(contents.pop_front());
               OP_POP_BACK:   void'(contents.pop_back());
               OP_READ_FRONT: res.read_data = contents[0];
               OP_READ_BACK:  res.read_data = contents[contents.size() - 1];
               OP_READ_AT: begin
                  if (pos >= contents.size())
                     res.status = ST_OOB;
                  else
                     res.read_data = contents[pos];
               end
               OP_REMOVE_AT: begin
                  if (pos >= contents.size())
                     res.status = ST_OOB;
                  else
                     contents.delete(pos);
               end
               default: ;
            endcase
         end
         res.count = COUNT_W'(contents.size());
         expected.push_back(res);
      endfunction

      function void report(string field, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      endfunction

      function void check_response(logic [READ_DATA_W-1:0] read_data,
                                   logic [STATUS_W-1:0] status, logic [COUNT_W-1:0] count);
         deque_result_type want;
         checked++;
         if (expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %h/%h/%h",
                     $time, read_data, status, count);
            return;
         end
         want = expected.pop_front();
         if (read_data !== want.read_data) report("read_data", want.read_data, read_data);
         if (status !== want.status) report("status", 32'(want.status), 32'(status));
         if (count !== want.count) report("count", 32'(want.count), 32'(count));
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [OPCODE_W-1:0]    req_tuser  = OP_PUSH_BACK;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [STATUS_W-1:0]    rsp_tuser;

   deque_scoreboard sb;
   bit              steady_run  = 1'b0;
   int unsigned     cycle_count = 0;

   indexed_deque_store dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[VALUE_W-1:0],
                            req_tdata[VALUE_W +: POSITION_W]);
         if (rsp_tvalid && rsp_tready)
            sb.check_response(rsp_tdata[READ_DATA_W-1:0], rsp_tuser,
                              rsp_tdata[READ_DATA_W +: COUNT_W]);
      end
   end

   // hold off responses once for a long stretch so the store backs up
   initial begin : rsp_side
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && sb.checked >= 400) begin
            hold_done = 1'b1;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else if (steady_run) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= 37);
         end
         @(negedge clock);
      end
   end

   task automatic send(logic [OPCODE_W-1:0] op, logic [VALUE_W-1:0] value,
                       logic [POSITION_W-1:0] pos);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W - VALUE_W - POSITION_W){1'b0}}, pos, value};
      req_tuser  <= op;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic idle_gaps();
      while (!steady_run && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.expected.size() != 0) @(negedge clock);
   endtask

   function automatic logic [OPCODE_W-1:0] pick_op(int mix);
      int unsigned roll;
      roll = $urandom_range(99);
      if (mix == MIX_GROW && roll < 80)
         return $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      if (mix == MIX_SHRINK && roll < 80) begin
         case (roll % 3)
            0:       return OP_POP_FRONT;
            1:       return OP_POP_BACK;
            default: return OP_REMOVE_AT;
         endcase
      end
      return OPCODE_W'($urandom_range(OP_PUSH_BACK, OP_REMOVE_AT));
   endfunction

   initial begin : stimulus
      int unsigned           n;
      int                    fill;
      int                    mix;
      logic [POSITION_W-1:0] pos;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty store: every non-push reports empty, ahead of the index check
      send(OP_POP_FRONT,  32'h0, 6'd0);
      send(OP_POP_BACK,   32'h0, 6'd0);
      send(OP_READ_FRONT, 32'h0, 6'd0);
      send(OP_READ_BACK,  32'h0, 6'd0);
      send(OP_READ_AT,    32'h0, 6'd0);
      send(OP_REMOVE_AT,  32'h0, 6'd63);
      // pop back on a single entry empties the store
      send(OP_PUSH_BACK,  32'hFFFF_FFFF, 6'd63);
      send(OP_POP_BACK,   32'h0, 6'd0);
      // push front from slot zero wraps the front around
      send(OP_PUSH_BACK,  32'h0000_0000, 6'd0);
      send(OP_PUSH_FRONT, 32'hFFFF_FFFF, 6'd63);
      send(OP_PUSH_BACK,  32'hA5A5_A5A5, 6'd21);
      send(OP_PUSH_FRONT, 32'h5A5A_5A5A, 6'd42);
      send(OP_READ_FRONT, 32'h0, 6'd0);
      send(OP_READ_BACK,  32'h0, 6'd0);
      send(OP_READ_AT,    32'h0, 6'd0);
      send(OP_READ_AT,    32'h0, 6'd3);
      send(OP_READ_AT,    32'h0, 6'd4);
      send(OP_READ_AT,    32'h0, 6'd63);
      // remove at index zero, out of range, then from the middle
      send(OP_REMOVE_AT,  32'h0, 6'd0);
      send(OP_REMOVE_AT,  32'h0, 6'd5);
      send(OP_REMOVE_AT,  32'h0, 6'd1);
      send(OP_POP_FRONT,  32'h0, 6'd0);
      send(OP_READ_AT,    32'h0, 6'd0);
      send(OP_POP_BACK,   32'h0, 6'd0);

      for (n = 0; n < RANDOM_ITEMS; n++) begin
         case ((n / 120) % 4)
            0:       mix = MIX_GROW;
            2:       mix = MIX_SHRINK;
            default: mix = MIX_EVEN;
         endcase
         steady_run = (n >= 700 && n < 950);
         if (n == 1200)
            wait_drained();
         fill = sb.contents.size();
         if (fill > 0 && $urandom_range(3) != 0)
            pos = POSITION_W'($urandom_range(fill - 1));
         else
            pos = POSITION_W'($urandom_range(STORE_DEPTH - 1));
         idle_gaps();
         send(pick_op(mix), $urandom, pos);
      end
      steady_run = 1'b0;

      wait_drained();
      repeat (200) @(negedge clock);
      if (sb.errors == 0 && sb.expected.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
